// ===== rtl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg: shared definitions for the box signed distance pipeline
// Holds the coordinate width and the widths derived from it for the
// intermediate values: per-axis offsets, squares, their sum and the root.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

	// Width of every coordinate and of the result (two's complement, Q16.16).
	localparam int COORD_WIDTH = 32;

	// Per-axis offset |p| - b needs two more bits than a coordinate.
	localparam int Q_WIDTH    = COORD_WIDTH + 2;
	// A clamped offset that is in range is positive and below 2^(W-1).
	localparam int CLAMP_WIDTH = COORD_WIDTH - 1;
	localparam int SQ_WIDTH   = 2 * CLAMP_WIDTH;
	// The sum of three squares stays below 2^(2W).
	localparam int SUM_WIDTH  = 2 * COORD_WIDTH;
	localparam int ROOT_WIDTH = SUM_WIDTH / 2;
	// The partial remainder never exceeds twice the partial root.
	localparam int REM_WIDTH  = ROOT_WIDTH + 2;

	localparam int NUM_AXES = 3;

	localparam logic [COORD_WIDTH-1:0] MAX_OUT = {1'b0, {(COORD_WIDTH-1){1'b1}}};

endpackage

`default_nettype wire

// ===== rtl/box_signed_distance.sv =====
// ----------------------------------------------------------------------------
// box_signed_distance: signed distance from a point to a centered box
// Fully pipelined evaluation of the box distance function on signed
// fixed-point coordinates, one query per clock cycle while the input is not stalled.
// ----------------------------------------------------------------------------
// The block takes one query transaction per clock cycle while in_stall is low
// and delivers one distance transaction for each, in order. The pipeline
// depth is set by the square root, which retires one root bit per pipeline
// stage. The stages are: offset |p| - b per axis, clamp and square, sum of
// squares, one stage per root bit, result selection, and the output register.
// A stalled output holds the whole pipeline only once its last stage is also
// full. Empty slots further up stay where they are, so the input can be held
// while the pipeline still has gaps in it. No state survives a transaction
// and nothing needs configuration.
`default_nettype none

module box_signed_distance (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] point_z,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] half_x,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] half_y,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] half_z,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [bsd_pkg::COORD_WIDTH-1:0]    distance
);

	import bsd_pkg::*;

	// The pipeline moves as one unit. It advances whenever its last stage
	// is empty or the output register can take that stage's result.
	logic pipe_en;
	logic out_room;

	// Stage 1: per-axis offset q = |p| - b.
	logic                       v_s1;
	logic signed [Q_WIDTH-1:0]  q_s1 [NUM_AXES];

	// Stage 2: squares of the clamped offsets, plus the flags and the
	// largest offset that the final selection needs.
	logic                       v_s2;
	logic [SQ_WIDTH-1:0]        sq_s2 [NUM_AXES];
	logic                       any_pos_s2;
	logic                       big_s2;
	logic signed [Q_WIDTH-1:0]  qmax_s2;

	// Stage 3: sum of squares.
	logic                       v_s3;
	logic [SUM_WIDTH-1:0]       sum_s3;
	logic                       any_pos_s3;
	logic                       big_s3;
	logic signed [Q_WIDTH-1:0]  qmax_s3;

	// Stage 4: one entry per root bit, most significant bit first.
	logic                       v_s4       [ROOT_WIDTH];
	logic [REM_WIDTH-1:0]       rem_s4     [ROOT_WIDTH];
	logic [ROOT_WIDTH-1:0]      root_s4    [ROOT_WIDTH];
	logic [SUM_WIDTH-1:0]       rad_s4     [ROOT_WIDTH];
	logic                       any_pos_s4 [ROOT_WIDTH];
	logic                       big_s4     [ROOT_WIDTH];
	logic signed [Q_WIDTH-1:0]  qmax_s4    [ROOT_WIDTH];

	// Stage 5: selected and saturated result.
	logic                         v_s5;
	logic [COORD_WIDTH-1:0]       dist_s5;

	// Output register.
	logic                         out_valid_q;
	logic [COORD_WIDTH-1:0]       distance_q;

	assign out_room  = !out_valid_q || !out_stall;
	assign pipe_en   = !v_s5 || out_room;
	assign in_stall  = !pipe_en;
	assign out_valid = out_valid_q;
	assign distance  = distance_q;

	// ------------------------------------------------------------------
	// Stage 1 logic: absolute value at full width, then subtract the half
	// extent. The most negative coordinate does not wrap.
	// ------------------------------------------------------------------
	logic signed [COORD_WIDTH-1:0] pt  [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hf  [NUM_AXES];
	logic signed [Q_WIDTH-1:0]     q_d [NUM_AXES];

	always_comb begin
		logic signed [COORD_WIDTH:0] p_ext;
		logic [COORD_WIDTH:0]        ap;
		pt[0] = point_x;
		pt[1] = point_y;
		pt[2] = point_z;
		hf[0] = half_x;
		hf[1] = half_y;
		hf[2] = half_z;
		for (int i = 0; i < NUM_AXES; i++) begin
			p_ext  = {pt[i][COORD_WIDTH-1], pt[i]};
			ap     = pt[i][COORD_WIDTH-1] ? (-p_ext) : p_ext;
			q_d[i] = $signed({1'b0, ap})
				- $signed({{(Q_WIDTH-COORD_WIDTH){hf[i][COORD_WIDTH-1]}}, hf[i]});
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 logic: an offset above the largest output value forces
	// saturation and is left out of the sum; negative offsets count as zero.
	// ------------------------------------------------------------------
	logic [CLAMP_WIDTH-1:0]      clamp_d [NUM_AXES];
	logic                        pos_d   [NUM_AXES];
	logic                        big_d   [NUM_AXES];
	logic signed [Q_WIDTH-1:0]   qmax_d;

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			pos_d[i]   = !q_s1[i][Q_WIDTH-1] && (q_s1[i] != '0);
			big_d[i]   = pos_d[i] && (q_s1[i][Q_WIDTH-2:CLAMP_WIDTH] != '0);
			clamp_d[i] = (pos_d[i] && !big_d[i]) ? q_s1[i][CLAMP_WIDTH-1:0] : '0;
		end
		qmax_d = q_s1[0];
		if (q_s1[1] > qmax_d) begin
			qmax_d = q_s1[1];
		end
		if (q_s1[2] > qmax_d) begin
			qmax_d = q_s1[2];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 logic: restoring square root, one root bit per stage. Each
	// stage brings down the next two radicand bits and tries 4*root + 1.
	// ------------------------------------------------------------------
	logic [REM_WIDTH-1:0]  rem_in   [ROOT_WIDTH];
	logic [ROOT_WIDTH-1:0] root_in  [ROOT_WIDTH];
	logic [SUM_WIDTH-1:0]  rad_in   [ROOT_WIDTH];
	logic [REM_WIDTH-1:0]  rem_nx   [ROOT_WIDTH];
	logic [ROOT_WIDTH-1:0] root_nx  [ROOT_WIDTH];

	always_comb begin
		logic [REM_WIDTH+1:0] cur;
		logic [REM_WIDTH+1:0] trial;
		for (int k = 0; k < ROOT_WIDTH; k++) begin
			if (k == 0) begin
				rem_in[k]  = '0;
				root_in[k] = '0;
				rad_in[k]  = sum_s3;
			end else begin
				rem_in[k]  = rem_s4[k-1];
				root_in[k] = root_s4[k-1];
				rad_in[k]  = rad_s4[k-1];
			end
			cur   = {rem_in[k], rad_in[k][SUM_WIDTH-1 -: 2]};
			trial = {{(REM_WIDTH-ROOT_WIDTH){1'b0}}, root_in[k], 2'b01};
			if (cur >= trial) begin
				rem_nx[k]  = REM_WIDTH'(cur - trial);
				root_nx[k] = {root_in[k][ROOT_WIDTH-2:0], 1'b1};
			end else begin
				rem_nx[k]  = cur[REM_WIDTH-1:0];
				root_nx[k] = {root_in[k][ROOT_WIDTH-2:0], 1'b0};
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5 logic: inside the box the result is the largest offset, which
	// always fits. Outside it is the root, saturated at the top.
	// ------------------------------------------------------------------
	localparam int LAST = ROOT_WIDTH - 1;
	logic [COORD_WIDTH-1:0] dist_d;

	always_comb begin
		if (!any_pos_s4[LAST]) begin
			dist_d = qmax_s4[LAST][COORD_WIDTH-1:0];
		end else if (big_s4[LAST]) begin
			dist_d = MAX_OUT;
		end else if (root_s4[LAST] > ROOT_WIDTH'(MAX_OUT)) begin
			dist_d = MAX_OUT;
		end else begin
			dist_d = COORD_WIDTH'(root_s4[LAST]);
		end
	end

	// ------------------------------------------------------------------
	// Valid bits.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < ROOT_WIDTH; k++) begin
				v_s4[k] <= 1'b0;
			end
		end else begin
			if (pipe_en) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4[0] <= v_s3;
				for (int k = 1; k < ROOT_WIDTH; k++) begin
					v_s4[k] <= v_s4[k-1];
				end
				v_s5 <= v_s4[LAST];
			end
			if (out_room) begin
				out_valid_q <= v_s5;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				q_s1[i]  <= q_d[i];
				sq_s2[i] <= SQ_WIDTH'(clamp_d[i] * clamp_d[i]);
			end
			any_pos_s2 <= pos_d[0] || pos_d[1] || pos_d[2];
			big_s2     <= big_d[0] || big_d[1] || big_d[2];
			qmax_s2    <= qmax_d;

			sum_s3     <= SUM_WIDTH'(sq_s2[0]) + SUM_WIDTH'(sq_s2[1])
				+ SUM_WIDTH'(sq_s2[2]);
			any_pos_s3 <= any_pos_s2;
			big_s3     <= big_s2;
			qmax_s3    <= qmax_s2;

			for (int k = 0; k < ROOT_WIDTH; k++) begin
				rem_s4[k]  <= rem_nx[k];
				root_s4[k] <= root_nx[k];
				rad_s4[k]  <= rad_in[k] << 2;
			end
			any_pos_s4[0] <= any_pos_s3;
			big_s4[0]     <= big_s3;
			qmax_s4[0]    <= qmax_s3;
			for (int k = 1; k < ROOT_WIDTH; k++) begin
				any_pos_s4[k] <= any_pos_s4[k-1];
				big_s4[k]     <= big_s4[k-1];
				qmax_s4[k]    <= qmax_s4[k-1];
			end

			dist_s5 <= dist_d;
		end
		if (out_room) begin
			distance_q <= dist_s5;
		end
	end

`ifndef SYNTH
	// The input side is held only when both the last stage and the output
	// register are full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s5 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	// An accepted transaction always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted transaction lost at stage 1");

	// The root remainder never exceeds twice the root.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4[LAST] |->
			({1'b0, rem_s4[LAST]} <= {{(REM_WIDTH-ROOT_WIDTH){1'b0}}, root_s4[LAST], 1'b0}))
		else $error("square root remainder out of bound");

	// A point inside the box never yields a positive distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_en && v_s4[LAST] && !any_pos_s4[LAST]) |=>
			(dist_s5[COORD_WIDTH-1] || (dist_s5 == '0)))
		else $error("positive distance for a point inside the box");
`endif

endmodule

`default_nettype wire

// ===== bench/box_distance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_distance_checker: distance prediction and comparison
// Watches both channels of the box signed distance block. Every accepted
// query yields a predicted distance. Every accepted distance is compared with
// the oldest prediction still outstanding.
// ----------------------------------------------------------------------------

module box_distance_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic                                  in_stall,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] point_z,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] half_x,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] half_y,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] half_z,
	input  wire logic                                  out_valid,
	input  wire logic                                  out_stall,
	input  wire logic signed [bsd_pkg::COORD_WIDTH-1:0] distance,
	output int                                         mismatch_count,
	output int                                         distances_due
);

	localparam int W = bsd_pkg::COORD_WIDTH;

	typedef logic signed [W-1:0] coord_t;
	// |p| - b needs two bits more than a coordinate.
	typedef logic signed [W+1:0] offset_t;

	localparam offset_t LARGEST = (offset_t'(1) <<< (W - 1)) - offset_t'(1);

	coord_t due_distances [$];
	coord_t wanted;

	function automatic coord_t box_distance(input coord_t px, input coord_t py,
			input coord_t pz, input coord_t hx, input coord_t hy, input coord_t hz);
		coord_t       pt [3];
		coord_t       hl [3];
		offset_t      mag;
		offset_t      q;
		offset_t      q_top;
		logic [127:0] qw;
		logic [127:0] sum_sq;
		logic [127:0] rem;
		logic [127:0] root;
		logic [127:0] probe;
		logic [127:0] step;
		logic         outside;
		logic         overflow;
		int           axis;
		int           k;

		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		hl[0] = hx;
		hl[1] = hy;
		hl[2] = hz;
		sum_sq   = '0;
		outside  = 1'b0;
		overflow = 1'b0;
		q_top    = '0;
		for (axis = 0; axis < 3; axis++) begin
			mag = (pt[axis] < 0) ? -offset_t'(pt[axis]) : offset_t'(pt[axis]);
			q = mag - offset_t'(hl[axis]);
			if (axis == 0 || q > q_top)
				q_top = q;
			if (q > 0) begin
				outside = 1'b1;
				if (q > LARGEST) begin
					overflow = 1'b1;
				end else begin
					qw = '0;
					qw[W+1:0] = q;
					sum_sq = sum_sq + qw * qw;
				end
			end
		end

		// Floor of the square root, one result bit per pass.
		rem  = sum_sq;
		root = '0;
		step = 128'b1 << 126;
		for (k = 0; k < 64; k++) begin
			probe = root + step;
			if (rem >= probe) begin
				rem  = rem - probe;
				root = (root >> 1) + step;
			end else begin
				root = root >> 1;
			end
			step = step >> 2;
		end

		if (!outside)
			return coord_t'(q_top);
		if (overflow || root > 128'(bsd_pkg::MAX_OUT))
			return bsd_pkg::MAX_OUT;
		return root[W-1:0];
	endfunction

	initial begin
		mismatch_count = 0;
		distances_due  = 0;
	end

	// The result side is handled before the query side, so a query accepted
	// in the same cycle can never be taken for the result that leaves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_distances.size() == 0) begin
					$display("%0t ns: distance %0d arrived with no query outstanding",
						$time, distance);
					mismatch_count <= mismatch_count + 1;
				end else begin
					wanted = due_distances.pop_front();
					if (distance !== wanted) begin
						$display("%0t ns: distance mismatch, expected %0d, got %0d",
							$time, wanted, distance);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				due_distances.push_back(box_distance(point_x, point_y, point_z,
					half_x, half_y, half_z));
			distances_due <= due_distances.size();
		end
	end

endmodule

// ===== bench/box_signed_distance_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_signed_distance_tb: stimulus and verdict for the box distance pipeline
// Sends a directed set of corner queries followed by a long random stream,
// with random gaps on the query side and random stalls on the result side.
// The checker instance beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module box_signed_distance_tb;

	localparam int W         = bsd_pkg::COORD_WIDTH;
	localparam int FRAC_BITS = 16;

	// The pipeline is as deep as the root is wide plus five stages.
	localparam int LATENCY          = bsd_pkg::ROOT_WIDTH + 5;
	localparam int DRAIN_CYCLES     = 2 * LATENCY;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int RANDOM_QUERIES   = 830;
	localparam int CYCLE_LIMIT      = 300000;

	typedef logic signed [W-1:0] coord_t;

	localparam coord_t C_MAX = bsd_pkg::MAX_OUT;
	localparam coord_t C_MIN = {1'b1, {(W - 1){1'b0}}};
	localparam coord_t ONE   = coord_t'(1 << FRAC_BITS);
	localparam coord_t HALF  = coord_t'(1 << (FRAC_BITS - 1));

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	coord_t half_x;
	coord_t half_y;
	coord_t half_z;
	logic   out_valid;
	logic   out_stall;
	coord_t distance;

	int mismatch_count;
	int distances_due;
	int queries_sent;
	int cycle_count;

	// Set by the stimulus process: quiet ends all idling on both sides, and
	// long_hold_wanted asks the result side for one long stall.
	logic quiet;
	logic long_hold_wanted;

	box_signed_distance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.half_x    (half_x),
		.half_y    (half_y),
		.half_z    (half_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.distance  (distance)
	);

	box_distance_checker distance_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_z        (point_z),
		.half_x         (half_x),
		.half_y         (half_y),
		.half_z         (half_z),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.distance       (distance),
		.mismatch_count (mismatch_count),
		.distances_due  (distances_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The watchdog only counts cycles. A hang anywhere in the pipeline or in
	// the handshakes ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Puts one query on the input channel at a falling edge and holds it
	// until a rising edge sees it accepted. Valid stays high afterwards, so
	// back-to-back calls give a transaction on every cycle the input is not stalled.
	task automatic offer_query(input coord_t px, input coord_t py, input coord_t pz,
			input coord_t hx, input coord_t hy, input coord_t hz);
		@(negedge clk);
		in_valid <= 1'b1;
		point_x  <= px;
		point_y  <= py;
		point_z  <= pz;
		half_x   <= hx;
		half_y   <= hy;
		half_z   <= hz;
		do
			@(posedge clk);
		while (in_stall);
		queries_sent++;
	endtask

	// Drops valid for the given number of cycles.
	task automatic idle_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	function automatic coord_t edge_value();
		case ($urandom_range(0, 7))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return -coord_t'(1);
			4: return coord_t'(1);
			5: return C_MIN + coord_t'(1);
			6: return C_MAX - coord_t'(1);
			default: return ONE;
		endcase
	endfunction

	function automatic coord_t signed_span(input int span);
		return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
	endfunction

	// Random queries come in several flavors. Raw words make every bit of
	// every field toggle. The scene-like, inside and near-surface flavors
	// keep the half extents non-negative and the point close to the box, which
	// is where the inside/outside decision and the root actually matter.
	task automatic random_query();
		coord_t v [6];
		coord_t h;
		coord_t p;
		int     pick;
		int     axis;

		pick = $urandom_range(0, 99);
		for (axis = 0; axis < 3; axis++) begin
			if (pick < 15) begin
				v[axis]     = coord_t'($urandom);
				v[axis + 3] = coord_t'($urandom);
			end else if (pick < 50) begin
				v[axis]     = signed_span(1 << 25);
				v[axis + 3] = coord_t'($urandom_range(0, 1 << 24));
			end else if (pick < 70) begin
				h = coord_t'($urandom_range(0, 1 << 28));
				p = coord_t'($urandom_range(0, h));
				v[axis]     = $urandom_range(0, 1) ? -p : p;
				v[axis + 3] = h;
			end else if (pick < 85) begin
				h = coord_t'($urandom_range(0, 1 << 28));
				p = h + coord_t'($urandom_range(0, 512)) - coord_t'(256);
				v[axis]     = $urandom_range(0, 1) ? -p : p;
				v[axis + 3] = h;
			end else begin
				v[axis]     = edge_value();
				v[axis + 3] = edge_value();
			end
		end
		offer_query(v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	// Result side. Stalls come at random, and once in the run a single long stall
	// lets the pipeline fill so that the block has to stall its own input while
	// queries keep coming.
	initial begin : result_side
		int  held;
		logic long_hold_done;

		out_stall      = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_wanted && !long_hold_done) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				for (held = 1; held < LONG_HOLD_CYCLES; held++)
					@(negedge clk);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15) - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int n;

		arst_n           = 1'b0;
		in_valid         = 1'b0;
		point_x          = '0;
		point_y          = '0;
		point_z          = '0;
		half_x           = '0;
		half_y           = '0;
		half_z           = '0;
		quiet            = 1'b0;
		long_hold_wanted = 1'b0;
		queries_sent     = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A point at the origin with a degenerate box.
		offer_query('0, '0, '0, '0, '0, '0);
		// Center of a unit box: the distance is minus one.
		offer_query('0, '0, '0, ONE, ONE, ONE);
		// Outside along one axis only.
		offer_query(2 * ONE, '0, '0, ONE, ONE, ONE);
		// Outside along two axes, a 3-4-5 triangle.
		offer_query(-4 * ONE, 5 * ONE, '0, ONE, ONE, ONE);
		// Outside along all three axes.
		offer_query(3 * ONE, -3 * ONE, 7 * ONE, ONE, 2 * ONE, ONE);
		// On the surface, with the other components inside: exactly zero.
		offer_query(ONE, '0, -HALF, ONE, ONE, ONE);
		// Negative half extents are taken as they are and push q outward.
		offer_query('0, '0, '0, -ONE, -ONE, -ONE);
		// The most negative coordinate has a magnitude beyond the output range.
		offer_query(C_MIN, '0, '0, '0, '0, '0);
		// Largest coordinate: q sits exactly at the top of the output range.
		offer_query(C_MAX, '0, '0, '0, '0, '0);
		// Three full-scale offsets: the length saturates.
		offer_query(C_MAX, C_MAX, C_MAX, '0, '0, '0);
		// Just above full scale through a small second component.
		offer_query(C_MAX, ONE, '0, '0, '0, '0);
		// Extreme point against the most negative extents.
		offer_query(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN);
		// Deepest point inside the largest box: the most negative result.
		offer_query('0, '0, '0, C_MAX, C_MAX, C_MAX);
		// Most negative points against the largest box: one LSB outside.
		offer_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		// Minus one against the most negative extent puts q above the output range.
		offer_query(-coord_t'(1), -coord_t'(1), -coord_t'(1), C_MIN, C_MIN, C_MIN);
		// One axis one LSB outside, the other two on the surface.
		offer_query(C_MIN, C_MAX, '0, C_MAX, C_MAX, '0);
		// Mixed inside components including the full-scale one.
		offer_query('0, '0, '0, '0, ONE, C_MAX);
		// Inside with fractional coordinates.
		offer_query(HALF, -(HALF / 2), HALF / 4, ONE, ONE, ONE);
		// A 5-12-13 triangle in raw LSBs.
		offer_query(coord_t'(-5), coord_t'(-12), '0, '0, '0, '0);
		// All ones everywhere.
		offer_query(-coord_t'(1), -coord_t'(1), -coord_t'(1),
			-coord_t'(1), -coord_t'(1), -coord_t'(1));

		// Random part, with the pressure events placed along the way.
		for (n = 0; n < RANDOM_QUERIES; n++) begin
			if (n == 150)
				long_hold_wanted = 1'b1;
			if (n == 450) begin
				// Let the pipeline run completely dry before going on.
				idle_sender(1);
				do
					@(posedge clk);
				while (distances_due != 0);
			end
			if (n == 700)
				quiet = 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0)
				idle_sender($urandom_range(1, 15));
			random_query();
		end

		// Drain: wait for every outstanding distance, then watch a while
		// longer for anything the block should not send.
		idle_sender(1);
		do
			@(posedge clk);
		while (distances_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && distances_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bsd_pkg.sv
rtl/box_signed_distance.sv
bench/box_distance_checker.sv
bench/box_signed_distance_tb.sv
